FILE: src/fwme_pkg.sv
// fwme_pkg: shared types and constants of the min-extract queue
// used by fwme_cell and fifo_with_min_extract; no dependencies
package fwme_pkg;

  localparam int unsigned FWME_DEPTH = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned FILL_W     = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQUEUE     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EXTRACT_MIN = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

  // per-cell control
  typedef struct packed {
    logic load;   // take the pushed value
    logic shift;  // take the value of the next cell
  } cell_ctrl_t;

endpackage

FILE: src/fwme_cell.sv
// fwme_cell: one storage place of the compacting queue with its own comparator
// depends on fwme_pkg
module fwme_cell (
  input  logic                       clk_i,
  input  fwme_pkg::cell_ctrl_t       ctrl_i,
  input  logic signed [31:0]         push_value_i,
  input  logic signed [31:0]         next_value_i,
  input  logic signed [31:0]         best_value_i,
  output logic signed [31:0]         value_o,
  output logic                       less_o
);
  import fwme_pkg::*;

  logic signed [DATA_W-1:0] value_q;
  logic signed [DATA_W-1:0] value_d;

  always_comb begin
    value_d = value_q;
    if (ctrl_i.load) begin
      value_d = push_value_i;
    end else if (ctrl_i.shift) begin
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // strict compare keeps the oldest of equal minima
  assign less_o  = value_q < best_value_i;

endmodule

FILE: src/fifo_with_min_extract.sv
// fifo_with_min_extract: compacting queue with enqueue, dequeue and extract-min
// top level; depends on fwme_pkg and fwme_cell
//
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: command, tdata: push_value
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: pop_value, fill_count; tuser: status
//
// enqueue, dequeue, unused codes and any refused command write their result when accepted
// extract-min scans for the minimum, visiting one cell per cycle through a single
// selection path, then shifts the cells behind the removed place
// reset empties the queue and the result register; cell contents are not cleared
// a new item is taken only when the controller is idle and the result register is
// empty or being drained in the same cycle; a stalled result holds its transfer
module fifo_with_min_extract #(
  parameter int unsigned DEPTH = fwme_pkg::FWME_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] push_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] pop_value, [35:32] fill_count, [39:36] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);
  import fwme_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_REMOVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]          occ_q, occ_d;
  logic [IdxW-1:0]          idx_q, idx_d;        // cell under inspection by the scan
  logic [IdxW-1:0]          best_idx_q, best_idx_d;
  logic signed [DATA_W-1:0] best_val_q, best_val_d;

  // result register
  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic [STATUS_W-1:0]      out_status_q, out_status_d;
  logic [FILL_W-1:0]        out_fill_q, out_fill_d;

  // cell row
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic                     cell_less  [DEPTH];
  cell_ctrl_t               cell_ctrl  [DEPTH];

  logic                     in_fire;
  logic                     out_free;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] push_value;
  logic                     full;
  logic                     empty;

  // removal and append requests to the cell row
  logic                     load_fire;
  logic                     remove_fire;
  logic [IdxW-1:0]          remove_pos;

  // result capture
  logic                     res_write;
  logic signed [DATA_W-1:0] res_value;
  logic [STATUS_W-1:0]      res_status;
  logic [CntW-1:0]          res_count;
  logic [CntW+FILL_W-1:0]   res_count_ext;

  assign cmd        = s_axis_tuser;
  assign push_value = s_axis_tdata;
  assign full       = (occ_q == CntW'(DEPTH));
  assign empty      = (occ_q == '0);
  assign out_free   = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // controller
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    load_fire   = 1'b0;
    remove_fire = 1'b0;
    remove_pos  = '0;
    res_write   = 1'b0;
    res_value   = '0;
    res_status  = STATUS_OK;
    res_count   = occ_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_ENQUEUE: begin
              res_write = 1'b1;
              if (full) begin
                res_status = STATUS_OVERFLOW;
              end else begin
                load_fire = 1'b1;
                occ_d     = occ_q + 1'b1;
                res_count = occ_q + 1'b1;
              end
            end
            CMD_DEQUEUE: begin
              res_write = 1'b1;
              if (empty) begin
                res_status = STATUS_UNDERFLOW;
              end else begin
                // oldest entry sits in cell zero
                remove_fire = 1'b1;
                res_value   = cell_value[0];
                occ_d       = occ_q - 1'b1;
                res_count   = occ_q - 1'b1;
              end
            end
            CMD_EXTRACT_MIN: begin
              if (empty) begin
                res_write  = 1'b1;
                res_status = STATUS_UNDERFLOW;
              end else begin
                // start with cell zero as the running minimum
                best_val_d = cell_value[0];
                best_idx_d = '0;
                idx_d      = IdxW'(1);
                state_d    = (occ_q == CntW'(1)) ? ST_REMOVE : ST_SCAN;
              end
            end
            default: begin
              res_write = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cell_less[idx_q]) begin
          best_val_d = cell_value[idx_q];
          best_idx_d = idx_q;
        end
        if (CntW'(idx_q) == occ_q - 1'b1) begin
          state_d = ST_REMOVE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_REMOVE: begin
        if (out_free) begin
          remove_fire = 1'b1;
          remove_pos  = best_idx_q;
          res_write   = 1'b1;
          res_value   = best_val_q;
          occ_d       = occ_q - 1'b1;
          res_count   = occ_q - 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fill_count carries the low bits of the count
  assign res_count_ext = {{FILL_W{1'b0}}, res_count};

  always_comb begin
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_fill_d   = out_fill_q;
    if (res_write) begin
      out_valid_d  = 1'b1;
      out_value_d  = res_value;
      out_status_d = res_status;
      out_fill_d   = res_count_ext[FILL_W-1:0];
    end else if (m_axis_tready) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      best_idx_q  <= best_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_val_q   <= best_val_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_fill_q   <= out_fill_d;
  end

  // cell row: append at the tail, shift forward behind a removed place
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] next_value;

    if (i == DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_mid
      assign next_value = cell_value[i+1];
    end

    always_comb begin
      cell_ctrl[i].load  = load_fire && (occ_q == CntW'(i));
      cell_ctrl[i].shift = remove_fire && (IdxW'(i) >= remove_pos);
    end

    fwme_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (cell_ctrl[i]),
      .push_value_i (push_value),
      .next_value_i (next_value),
      .best_value_i (best_val_q),
      .value_o      (cell_value[i]),
      .less_o       (cell_less[i])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_fill_q, out_value_q};
  assign m_axis_tuser  = out_status_q;

  // checks

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(DEPTH))
    else $error("queue count above depth");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (idx_q != '0) && (CntW'(idx_q) < occ_q))
    else $error("scan index outside held entries");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (cmd == CMD_ENQUEUE) && !full) |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("enqueue did not grow the queue");

  a_remove_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REMOVE && out_free) |=>
      (out_valid_q && out_status_q == STATUS_OK && state_q == ST_IDLE))
    else $error("extract-min removal gave no result");

endmodule
